### rtl/esds_pkg.sv
// ----------------------------------------------------------------------------
// esds_pkg
// Types, codes and constants shared by the esds descriptor parser.
// ----------------------------------------------------------------------------
package esds_pkg;

  localparam int unsigned MAX_LEN_BYTES = 4;
  localparam int unsigned LEN_W         = 28;
  localparam int unsigned ADDR_W        = 4;
  localparam int unsigned DATA_W        = 32;

  localparam logic [7:0] LEN_DATA_MASK = 8'h7F;
  localparam logic [7:0] LEN_MORE_BIT  = 8'h80;
  localparam logic [LEN_W-1:0] ES_LEN_MIN  = LEN_W'(5 + 15);
  localparam logic [LEN_W-1:0] DC_LEN_MIN  = LEN_W'(15);

  // register indexes
  localparam logic [1:0] REG_ES_TAG  = 2'd0;
  localparam logic [1:0] REG_DC_TAG  = 2'd1;
  localparam logic [1:0] REG_DS_TAG  = 2'd2;
  localparam logic [1:0] REG_SL_TAG  = 2'd3;

  localparam logic [7:0] ES_TAG_RST  = 8'd3;
  localparam logic [7:0] DC_TAG_RST  = 8'd4;
  localparam logic [7:0] DS_TAG_RST  = 8'd5;
  localparam logic [7:0] SL_TAG_RST  = 8'd6;

  // result kinds
  localparam logic [2:0] KIND_DS_BYTE     = 3'd0;
  localparam logic [2:0] KIND_SL_BYTE     = 3'd1;
  localparam logic [2:0] KIND_SUMMARY     = 3'd2;
  localparam logic [2:0] KIND_SUMMARY_DS  = 3'd3;
  localparam logic [2:0] KIND_SUMMARY_SL  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  // two-entry queue occupancy at full
  localparam logic [1:0] QUEUE_FULL = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       atom_end;
  } esds_in_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       payload_byte;
    logic [15:0]      es_id;
    logic [7:0]       stream_priority;
    logic [7:0]       object_type;
    logic [7:0]       stream_kind;
    logic [23:0]      buffer_size;
    logic [31:0]      peak_rate;
    logic [31:0]      mean_rate;
    logic [LEN_W-1:0] specific_len;
    logic [LEN_W-1:0] sl_len;
    logic [1:0]       status;
  } esds_out_t;

  typedef struct packed {
    logic [7:0] es_tag;
    logic [7:0] dec_config_tag;
    logic [7:0] dec_specific_tag;
    logic [7:0] sl_config_tag;
  } esds_cfg_t;

endpackage

### rtl/esds_descriptor_parser.sv
// ----------------------------------------------------------------------------
// esds_descriptor_parser
// MPEG-4 esds atom parser: byte stream in, pass-through bytes and one
// summary word per atom out.
//
//   channel   direction  handshake           word
//   bytes     in         push / full         esds_in_t  (data_byte, atom_end)
//   results   out        empty / pop         esds_out_t (kind .. status)
//   config    in         psel/penable/pwrite tag registers at 0x0..0xC
//
// One byte per cycle sustained while the result queue is not full; a byte's
// result word passes from the byte queue through the parse core into the
// result queue. The parser steps only when the result queue is not full, even
// on a pop; with a result on every byte, a missed pop raises full and holds
// the parser. Reset empties both queues and clears the parse state at once;
// it returns the tag registers to their reset values.
// ----------------------------------------------------------------------------
module esds_descriptor_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  input  esds_pkg::esds_in_t          in_item_i,
  output logic                        full,
  output logic                        empty,
  output esds_pkg::esds_out_t         out_item_o,
  input  logic                        pop,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [esds_pkg::ADDR_W-1:0] paddr,
  input  logic [esds_pkg::DATA_W-1:0] pwdata,
  output logic [esds_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import esds_pkg::*;

  esds_cfg_t cfg;
  esds_in_t  q_item;
  esds_out_t core_item;
  logic      q_valid, core_ready, core_valid, res_full, res_valid;

  esds_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  esds_byte_queue u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item_i),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (core_ready)
  );

  esds_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (q_valid),
    .in_item_i   (q_item),
    .in_ready_o  (core_ready),
    .out_valid_o (core_valid),
    .out_item_o  (core_item),
    .out_ready_i (~res_full)
  );

  esds_result_queue u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_valid),
    .item_i  (core_item),
    .full_o  (res_full),
    .valid_o (res_valid),
    .item_o  (out_item_o),
    .pop_i   (pop)
  );

  assign empty = ~res_valid;

endmodule

### rtl/esds_cfg_regs.sv
// ----------------------------------------------------------------------------
// esds_cfg_regs
// APB-style register file holding the four descriptor tag bytes.
// ----------------------------------------------------------------------------
module esds_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [esds_pkg::ADDR_W-1:0] paddr,
  input  logic [esds_pkg::DATA_W-1:0] pwdata,
  output logic [esds_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output esds_pkg::esds_cfg_t        cfg_o
);
  import esds_pkg::*;

  esds_cfg_t  cfg_q, cfg_d;
  logic [1:0] idx;
  logic       wr_en;
  logic [7:0] rd_byte;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ES_TAG: cfg_d.es_tag           = pwdata[7:0];
        REG_DC_TAG: cfg_d.dec_config_tag   = pwdata[7:0];
        REG_DS_TAG: cfg_d.dec_specific_tag = pwdata[7:0];
        REG_SL_TAG: cfg_d.sl_config_tag    = pwdata[7:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ES_TAG: rd_byte = cfg_q.es_tag;
      REG_DC_TAG: rd_byte = cfg_q.dec_config_tag;
      REG_DS_TAG: rd_byte = cfg_q.dec_specific_tag;
      REG_SL_TAG: rd_byte = cfg_q.sl_config_tag;
      default:    rd_byte = 8'd0;
    endcase
  end

  assign prdata = {(DATA_W-8)'(0), rd_byte};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.es_tag           <= ES_TAG_RST;
      cfg_q.dec_config_tag   <= DC_TAG_RST;
      cfg_q.dec_specific_tag <= DS_TAG_RST;
      cfg_q.sl_config_tag    <= SL_TAG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/esds_byte_queue.sv
// ----------------------------------------------------------------------------
// esds_byte_queue
// Front end: two-entry queue that takes atom bytes from the input side.
// ----------------------------------------------------------------------------
module esds_byte_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  esds_pkg::esds_in_t item_i,
  output logic               full_o,
  output logic               valid_o,
  output esds_pkg::esds_in_t item_o,
  input  logic               pop_i
);
  import esds_pkg::*;

  esds_in_t   mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == QUEUE_FULL);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/esds_parse_core.sv
// ----------------------------------------------------------------------------
// esds_parse_core
// Parse core: byte-wide descriptor state machine, one byte per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module esds_parse_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  esds_pkg::esds_cfg_t cfg_i,
  input  logic                in_valid_i,
  input  esds_pkg::esds_in_t  in_item_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output esds_pkg::esds_out_t out_item_o,
  input  logic                out_ready_i
);
  import esds_pkg::*;

  localparam logic [4:0] PH_VER        = 5'd0;
  localparam logic [4:0] PH_FLAGS      = 5'd1;
  localparam logic [4:0] PH_TAG_ES     = 5'd2;
  localparam logic [4:0] PH_ES_LEN     = 5'd3;
  localparam logic [4:0] PH_ES_ID      = 5'd4;
  localparam logic [4:0] PH_ES_ID_BARE = 5'd5;
  localparam logic [4:0] PH_PRIO       = 5'd6;
  localparam logic [4:0] PH_TAG_DC     = 5'd7;
  localparam logic [4:0] PH_DC_LEN     = 5'd8;
  localparam logic [4:0] PH_OBJ        = 5'd9;
  localparam logic [4:0] PH_STYPE      = 5'd10;
  localparam logic [4:0] PH_BUF        = 5'd11;
  localparam logic [4:0] PH_PEAK       = 5'd12;
  localparam logic [4:0] PH_MEAN       = 5'd13;
  localparam logic [4:0] PH_TAG_DS     = 5'd14;
  localparam logic [4:0] PH_DS_LEN     = 5'd15;
  localparam logic [4:0] PH_DS_DATA    = 5'd16;
  localparam logic [4:0] PH_TAG_SL     = 5'd17;
  localparam logic [4:0] PH_SL_LEN     = 5'd18;
  localparam logic [4:0] PH_SL_DATA    = 5'd19;
  localparam logic [4:0] PH_DONE       = 5'd20;

  logic [4:0]       phase_q, phase_d;
  logic [2:0]       fbc_q, fbc_d;
  logic [LEN_W-1:0] acc_q, acc_d;
  logic [2:0]       vcnt_q, vcnt_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic [15:0]      es_id_q, es_id_d;
  logic [7:0]       prio_q, prio_d;
  logic [7:0]       obj_q, obj_d;
  logic [7:0]       stype_q, stype_d;
  logic [23:0]      buf_q, buf_d;
  logic [31:0]      peak_q, peak_d;
  logic [31:0]      mean_q, mean_d;
  logic [LEN_W-1:0] spec_len_q, spec_len_d;
  logic [LEN_W-1:0] sl_len_q, sl_len_d;
  logic [1:0]       status_q, status_d;

  logic             fire;
  logic [7:0]       b;
  logic [2:0]       fbc_inc, vcnt_inc;
  logic [LEN_W-1:0] acc_shift, left_dec;
  logic             len_last;
  logic             pass_ds, pass_sl;
  logic [1:0]       sum_status;
  esds_out_t        res;

  assign fire       = in_valid_i & out_ready_i;
  assign in_ready_o = out_ready_i;
  assign b          = in_item_i.data_byte;
  assign fbc_inc    = fbc_q + 3'd1;
  assign vcnt_inc   = vcnt_q + 3'd1;
  assign acc_shift  = {acc_q[LEN_W-8:0], b[6:0] & LEN_DATA_MASK[6:0]};
  assign len_last   = ((b & LEN_MORE_BIT) == 8'd0) || (vcnt_inc >= 3'(MAX_LEN_BYTES));
  assign left_dec   = left_q - LEN_W'(1);

  always_comb begin
    phase_d    = phase_q;
    fbc_d      = fbc_q;
    acc_d      = acc_q;
    vcnt_d     = vcnt_q;
    left_d     = left_q;
    es_id_d    = es_id_q;
    prio_d     = prio_q;
    obj_d      = obj_q;
    stype_d    = stype_q;
    buf_d      = buf_q;
    peak_d     = peak_q;
    mean_d     = mean_q;
    spec_len_d = spec_len_q;
    sl_len_d   = sl_len_q;
    status_d   = status_q;
    pass_ds    = 1'b0;
    pass_sl    = 1'b0;

    unique case (phase_q)
      PH_VER: begin
        phase_d = PH_FLAGS;
        fbc_d   = 3'd0;
      end
      PH_FLAGS: begin
        fbc_d = fbc_inc;
        if (fbc_inc >= 3'd3) begin
          fbc_d   = 3'd0;
          phase_d = PH_TAG_ES;
        end
      end
      PH_TAG_ES: begin
        fbc_d = 3'd0;
        if (b == cfg_i.es_tag) begin
          acc_d   = '0;
          vcnt_d  = 3'd0;
          phase_d = PH_ES_LEN;
        end else begin
          phase_d = PH_ES_ID_BARE;
        end
      end
      PH_ES_LEN: begin
        acc_d  = acc_shift;
        vcnt_d = vcnt_inc;
        if (len_last) begin
          fbc_d   = 3'd0;
          phase_d = PH_ES_ID;
        end
      end
      PH_ES_ID, PH_ES_ID_BARE: begin
        es_id_d = {es_id_q[7:0], b};
        fbc_d   = fbc_inc;
        if (fbc_inc >= 3'd2) begin
          fbc_d   = 3'd0;
          phase_d = (phase_q == PH_ES_ID) ? PH_PRIO : PH_TAG_DC;
        end
      end
      PH_PRIO: begin
        prio_d = b;
        if (acc_q < ES_LEN_MIN) begin
          status_d = ST_MALFORMED;
          phase_d  = PH_DONE;
        end else begin
          phase_d = PH_TAG_DC;
        end
      end
      PH_TAG_DC: begin
        if (b != cfg_i.dec_config_tag) begin
          status_d = ST_MALFORMED;
          phase_d  = PH_DONE;
        end else begin
          acc_d   = '0;
          vcnt_d  = 3'd0;
          phase_d = PH_DC_LEN;
        end
      end
      PH_DC_LEN: begin
        acc_d  = acc_shift;
        vcnt_d = vcnt_inc;
        if (len_last) begin
          phase_d = PH_OBJ;
        end
      end
      PH_OBJ: begin
        obj_d   = b;
        phase_d = PH_STYPE;
      end
      PH_STYPE: begin
        stype_d = b;
        fbc_d   = 3'd0;
        phase_d = PH_BUF;
      end
      PH_BUF: begin
        buf_d = {buf_q[15:0], b};
        fbc_d = fbc_inc;
        if (fbc_inc >= 3'd3) begin
          fbc_d   = 3'd0;
          phase_d = PH_PEAK;
        end
      end
      PH_PEAK: begin
        peak_d = {peak_q[23:0], b};
        fbc_d  = fbc_inc;
        if (fbc_inc >= 3'd4) begin
          fbc_d   = 3'd0;
          phase_d = PH_MEAN;
        end
      end
      PH_MEAN: begin
        mean_d = {mean_q[23:0], b};
        fbc_d  = fbc_inc;
        if (fbc_inc >= 3'd4) begin
          fbc_d = 3'd0;
          if (acc_q < DC_LEN_MIN) begin
            status_d = ST_OK;
            phase_d  = PH_DONE;
          end else begin
            phase_d = PH_TAG_DS;
          end
        end
      end
      PH_TAG_DS: begin
        if (b != cfg_i.dec_specific_tag) begin
          status_d = ST_OK;
          phase_d  = PH_DONE;
        end else begin
          acc_d   = '0;
          vcnt_d  = 3'd0;
          phase_d = PH_DS_LEN;
        end
      end
      PH_DS_LEN: begin
        acc_d  = acc_shift;
        vcnt_d = vcnt_inc;
        if (len_last) begin
          spec_len_d = acc_shift;
          left_d     = acc_shift;
          phase_d    = (acc_shift != '0) ? PH_DS_DATA : PH_TAG_SL;
        end
      end
      PH_DS_DATA: begin
        pass_ds = 1'b1;
        left_d  = left_dec;
        if (left_dec == '0) begin
          phase_d = PH_TAG_SL;
        end
      end
      PH_TAG_SL: begin
        if (b != cfg_i.sl_config_tag) begin
          status_d = ST_OK;
          phase_d  = PH_DONE;
        end else begin
          acc_d   = '0;
          vcnt_d  = 3'd0;
          phase_d = PH_SL_LEN;
        end
      end
      PH_SL_LEN: begin
        acc_d  = acc_shift;
        vcnt_d = vcnt_inc;
        if (len_last) begin
          sl_len_d = acc_shift;
          left_d   = acc_shift;
          if (acc_shift == '0) begin
            status_d = ST_OK;
            phase_d  = PH_DONE;
          end else begin
            phase_d = PH_SL_DATA;
          end
        end
      end
      PH_SL_DATA: begin
        pass_sl = 1'b1;
        left_d  = left_dec;
        if (left_dec == '0) begin
          status_d = ST_OK;
          phase_d  = PH_DONE;
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    priority if (phase_d == PH_DONE) begin
      sum_status = status_d;
    end else if (phase_d == PH_TAG_DS || phase_d == PH_TAG_SL) begin
      sum_status = ST_OK;
    end else begin
      sum_status = ST_TRUNCATED;
    end

    res = '0;
    if (in_item_i.atom_end) begin
      res.kind            = pass_ds ? KIND_SUMMARY_DS :
                            (pass_sl ? KIND_SUMMARY_SL : KIND_SUMMARY);
      res.payload_byte    = (pass_ds | pass_sl) ? b : 8'd0;
      res.es_id           = es_id_d;
      res.stream_priority = prio_d;
      res.object_type     = obj_d;
      res.stream_kind     = stype_d;
      res.buffer_size     = buf_d;
      res.peak_rate       = peak_d;
      res.mean_rate       = mean_d;
      res.specific_len    = spec_len_d;
      res.sl_len          = sl_len_d;
      res.status          = sum_status;
      phase_d    = PH_VER;
      fbc_d      = 3'd0;
      acc_d      = '0;
      vcnt_d     = 3'd0;
      left_d     = '0;
      es_id_d    = '0;
      prio_d     = '0;
      obj_d      = '0;
      stype_d    = '0;
      buf_d      = '0;
      peak_d     = '0;
      mean_d     = '0;
      spec_len_d = '0;
      sl_len_d   = '0;
      status_d   = ST_OK;
    end else begin
      res.kind         = pass_ds ? KIND_DS_BYTE : KIND_SL_BYTE;
      res.payload_byte = b;
    end
  end

  assign out_valid_o = fire & (in_item_i.atom_end | pass_ds | pass_sl);
  assign out_item_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_VER;
      fbc_q      <= 3'd0;
      acc_q      <= '0;
      vcnt_q     <= 3'd0;
      left_q     <= '0;
      es_id_q    <= '0;
      prio_q     <= '0;
      obj_q      <= '0;
      stype_q    <= '0;
      buf_q      <= '0;
      peak_q     <= '0;
      mean_q     <= '0;
      spec_len_q <= '0;
      sl_len_q   <= '0;
      status_q   <= ST_OK;
    end else if (fire) begin
      phase_q    <= phase_d;
      fbc_q      <= fbc_d;
      acc_q      <= acc_d;
      vcnt_q     <= vcnt_d;
      left_q     <= left_d;
      es_id_q    <= es_id_d;
      prio_q     <= prio_d;
      obj_q      <= obj_d;
      stype_q    <= stype_d;
      buf_q      <= buf_d;
      peak_q     <= peak_d;
      mean_q     <= mean_d;
      spec_len_q <= spec_len_d;
      sl_len_q   <= sl_len_d;
      status_q   <= status_d;
    end
  end

endmodule

### rtl/esds_result_queue.sv
// ----------------------------------------------------------------------------
// esds_result_queue
// Two-entry queue of result words toward the output side.
// ----------------------------------------------------------------------------
module esds_result_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  esds_pkg::esds_out_t item_i,
  output logic                full_o,
  output logic                valid_o,
  output esds_pkg::esds_out_t item_o,
  input  logic                pop_i
);
  import esds_pkg::*;

  esds_out_t  mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == QUEUE_FULL);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/esds_checker.sv
// ----------------------------------------------------------------------------
// esds_checker
// Port-level checks on the esds descriptor parser, bound to the top level.
// ----------------------------------------------------------------------------
module esds_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input esds_pkg::esds_out_t out_item_o,
  input logic                pop
);
  import esds_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result word changed while waiting");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.kind == KIND_DS_BYTE || out_item_o.kind == KIND_SL_BYTE ||
                out_item_o.kind == KIND_SUMMARY || out_item_o.kind == KIND_SUMMARY_DS ||
                out_item_o.kind == KIND_SUMMARY_SL))
    else $error("illegal result kind");

  a_bytes_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_item_o.kind == KIND_DS_BYTE || out_item_o.kind == KIND_SL_BYTE))
    |-> (out_item_o.es_id == 16'd0 && out_item_o.status == ST_OK &&
         out_item_o.specific_len == '0 && out_item_o.sl_len == '0))
    else $error("pass-through word carries summary fields");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.kind == KIND_SUMMARY) |->
      (out_item_o.payload_byte == 8'd0 && out_item_o.status != 2'd3))
    else $error("bad summary word");

endmodule

bind esds_descriptor_parser esds_checker u_esds_checker (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// esds descriptor parser testbench
// Streams esds atom bodies into the parser, byte by byte, and checks every
// pass-through byte and summary word against a cycle-free model of the parse
// kept in this file. Atoms are mostly well formed with random content, with
// short lengths, wrong and missing tags, truncation and noise mixed in. Tag
// registers are changed between phases and inside an atom in each of three rounds.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import esds_pkg::*;

  typedef enum logic [4:0] {
    P_VER, P_FLAGS, P_ES_TAG, P_ES_LEN, P_ES_ID, P_BARE_ID, P_PRIO,
    P_DC_TAG, P_DC_LEN, P_OBJ, P_STYPE, P_BUF, P_PEAK, P_MEAN,
    P_DS_TAG, P_DS_LEN, P_DS_DATA, P_SL_TAG, P_SL_LEN, P_SL_DATA, P_DONE
  } parse_phase_e;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              push    = 1'b0;
  esds_in_t          in_item = '0;
  logic              full;
  logic              empty;
  esds_out_t         out_item;
  logic              pop     = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  esds_descriptor_parser dut (
    .clk_i,
    .rst_ni,
    .push,
    .in_item_i  (in_item),
    .full,
    .empty,
    .out_item_o (out_item),
    .pop,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // parse model state
  esds_cfg_t    tags;
  parse_phase_e ph;
  int           fld_cnt;
  logic [27:0]  len_acc;
  int           len_cnt;
  logic [27:0]  bytes_left;
  esds_out_t    cap;
  logic [1:0]   parse_st;
  bit           parse_fin;

  esds_out_t  due_words[$];
  logic [7:0] atom_bytes[$];
  int         errors = 0;
  bit         send_gaps = 1'b1;
  bit         pop_gaps = 1'b1;

  function automatic void clear_parse();
    ph = P_VER;
    fld_cnt = 0;
    len_acc = '0;
    len_cnt = 0;
    bytes_left = '0;
    cap = '0;
    parse_st = ST_OK;
    parse_fin = 1'b0;
  endfunction

  function automatic void conclude(logic [1:0] st);
    parse_st = st;
    parse_fin = 1'b1;
    ph = P_DONE;
  endfunction

  function automatic void open_len(parse_phase_e nxt);
    len_acc = '0;
    len_cnt = 0;
    ph = nxt;
  endfunction

  function automatic bit len_step(logic [7:0] b);
    len_acc = {len_acc[20:0], b[6:0]};
    len_cnt++;
    return ((b & LEN_MORE_BIT) == 0) || (len_cnt >= MAX_LEN_BYTES);
  endfunction

  function automatic bit field_done(int n);
    fld_cnt++;
    if (fld_cnt >= n) begin
      fld_cnt = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void parse_esds_byte(esds_in_t w);
    logic [7:0] b;
    bit         passed;
    logic [2:0] pass_kind;
    esds_out_t  word;
    b = w.data_byte;
    passed = 1'b0;
    pass_kind = KIND_DS_BYTE;
    case (ph)
      P_VER: begin
        ph = P_FLAGS;
        fld_cnt = 0;
      end
      P_FLAGS: begin
        fld_cnt++;
        if (fld_cnt >= 3) begin
          fld_cnt = 0;
          ph = P_ES_TAG;
        end
      end
      P_ES_TAG: begin
        fld_cnt = 0;
        if (b == tags.es_tag) open_len(P_ES_LEN);
        else ph = P_BARE_ID;
      end
      P_ES_LEN: begin
        if (len_step(b)) begin
          fld_cnt = 0;
          ph = P_ES_ID;
        end
      end
      P_ES_ID: begin
        cap.es_id = {cap.es_id[7:0], b};
        if (field_done(2)) ph = P_PRIO;
      end
      P_BARE_ID: begin
        cap.es_id = {cap.es_id[7:0], b};
        if (field_done(2)) ph = P_DC_TAG;
      end
      P_PRIO: begin
        cap.stream_priority = b;
        if (len_acc < ES_LEN_MIN) conclude(ST_MALFORMED);
        else ph = P_DC_TAG;
      end
      P_DC_TAG: begin
        if (b != tags.dec_config_tag) conclude(ST_MALFORMED);
        else open_len(P_DC_LEN);
      end
      P_DC_LEN: begin
        if (len_step(b)) ph = P_OBJ;
      end
      P_OBJ: begin
        cap.object_type = b;
        ph = P_STYPE;
      end
      P_STYPE: begin
        cap.stream_kind = b;
        fld_cnt = 0;
        ph = P_BUF;
      end
      P_BUF: begin
        cap.buffer_size = {cap.buffer_size[15:0], b};
        if (field_done(3)) ph = P_PEAK;
      end
      P_PEAK: begin
        cap.peak_rate = {cap.peak_rate[23:0], b};
        if (field_done(4)) ph = P_MEAN;
      end
      P_MEAN: begin
        cap.mean_rate = {cap.mean_rate[23:0], b};
        if (field_done(4)) begin
          if (len_acc < DC_LEN_MIN) conclude(ST_OK);
          else ph = P_DS_TAG;
        end
      end
      P_DS_TAG: begin
        if (b != tags.dec_specific_tag) conclude(ST_OK);
        else open_len(P_DS_LEN);
      end
      P_DS_LEN: begin
        if (len_step(b)) begin
          cap.specific_len = len_acc;
          bytes_left = len_acc;
          ph = (len_acc != 0) ? P_DS_DATA : P_SL_TAG;
        end
      end
      P_DS_DATA: begin
        passed = 1'b1;
        pass_kind = KIND_DS_BYTE;
        bytes_left--;
        if (bytes_left == 0) ph = P_SL_TAG;
      end
      P_SL_TAG: begin
        if (b != tags.sl_config_tag) conclude(ST_OK);
        else open_len(P_SL_LEN);
      end
      P_SL_LEN: begin
        if (len_step(b)) begin
          cap.sl_len = len_acc;
          bytes_left = len_acc;
          if (len_acc == 0) conclude(ST_OK);
          else ph = P_SL_DATA;
        end
      end
      P_SL_DATA: begin
        passed = 1'b1;
        pass_kind = KIND_SL_BYTE;
        bytes_left--;
        if (bytes_left == 0) conclude(ST_OK);
      end
      default: ph = P_DONE;
    endcase

    word = '0;
    if (w.atom_end) begin
      word = cap;
      if (parse_fin) word.status = parse_st;
      else if (ph == P_DS_TAG || ph == P_SL_TAG) word.status = ST_OK;
      else word.status = ST_TRUNCATED;
      if (!passed) word.kind = KIND_SUMMARY;
      else if (pass_kind == KIND_DS_BYTE) word.kind = KIND_SUMMARY_DS;
      else word.kind = KIND_SUMMARY_SL;
      word.payload_byte = passed ? b : 8'h00;
      due_words.push_back(word);
      clear_parse();
    end else if (passed) begin
      word.kind = pass_kind;
      word.payload_byte = b;
      due_words.push_back(word);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void compare_word(esds_out_t want, esds_out_t got);
    check_field("kind", 32'(want.kind), 32'(got.kind));
    check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
    check_field("es_id", 32'(want.es_id), 32'(got.es_id));
    check_field("stream_priority", 32'(want.stream_priority), 32'(got.stream_priority));
    check_field("object_type", 32'(want.object_type), 32'(got.object_type));
    check_field("stream_kind", 32'(want.stream_kind), 32'(got.stream_kind));
    check_field("buffer_size", 32'(want.buffer_size), 32'(got.buffer_size));
    check_field("peak_rate", want.peak_rate, got.peak_rate);
    check_field("mean_rate", want.mean_rate, got.mean_rate);
    check_field("specific_len", 32'(want.specific_len), 32'(got.specific_len));
    check_field("sl_len", 32'(want.sl_len), 32'(got.sl_len));
    check_field("status", 32'(want.status), 32'(got.status));
  endfunction

  initial begin : result_checker
    int        stall;
    esds_out_t got;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got = out_item;
        if (due_words.size() == 0) begin
          $error("result word with nothing expected, kind %0d", got.kind);
          errors++;
        end else begin
          compare_word(due_words.pop_front(), got);
        end
      end
      if (stall > 0) stall--;
      else if (pop_gaps && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 15);
      pop <= (stall == 0);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    esds_in_t w;
    w.data_byte = b;
    w.atom_end = last;
    if (send_gaps && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item <= w;
    do @(posedge clk_i); while (full);
    parse_esds_byte(w);
  endtask

  task automatic send_atom(input int from, input int upto);
    for (int i = from; i < upto; i++) begin
      send_byte(atom_bytes[i], i == atom_bytes.size() - 1);
    end
  endtask

  // drain results, then give bytes that produce nothing time to clear the pipe
  task automatic settle();
    push <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_tag(input logic [1:0] idx, input logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ES_TAG: tags.es_tag = v;
      REG_DC_TAG: tags.dec_config_tag = v;
      REG_DS_TAG: tags.dec_specific_tag = v;
      REG_SL_TAG: tags.sl_config_tag = v;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all_tags(input logic [7:0] es, input logic [7:0] dc,
                                input logic [7:0] ds, input logic [7:0] sl);
    settle();
    write_tag(REG_ES_TAG, es);
    write_tag(REG_DC_TAG, dc);
    write_tag(REG_DS_TAG, ds);
    write_tag(REG_SL_TAG, sl);
  endtask

  function automatic logic [7:0] other_than(logic [7:0] t);
    return t + 8'($urandom_range(1, 255));
  endfunction

  function automatic void put_rand(int n);
    for (int i = 0; i < n; i++) atom_bytes.push_back(8'($urandom));
  endfunction

  // varint, sometimes padded with leading zero groups or with a dangling
  // continuation bit on the fourth byte
  function automatic void put_len(logic [27:0] v);
    int          need;
    int          n;
    logic [27:0] grp;
    logic        more;
    need = 1;
    while (need < MAX_LEN_BYTES && (v >> (7 * need)) != 0) need++;
    n = ($urandom_range(0, 3) == 0) ? int'($urandom_range(need, MAX_LEN_BYTES)) : need;
    for (int i = n - 1; i >= 0; i--) begin
      grp = v >> (7 * i);
      more = (i != 0) || (n == MAX_LEN_BYTES && $urandom_range(0, 1) == 1);
      atom_bytes.push_back({more, grp[6:0]});
    end
  endfunction

  // returns 0 when the atom ends inside or before this descriptor
  function automatic bit add_desc(logic [7:0] tag);
    int          pick;
    logic [27:0] n;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 1'b0;
    if (pick == 1) begin
      atom_bytes.push_back(other_than(tag));
      return 1'b1;
    end
    atom_bytes.push_back(tag);
    if (pick == 2) begin
      n = 28'($urandom);
      put_len(n);
      put_rand($urandom_range(0, 8));
      return 1'b0;
    end
    n = 28'($urandom_range(0, 6));
    put_len(n);
    put_rand(int'(n));
    return 1'b1;
  endfunction

  function automatic void make_atom();
    logic [27:0] len;
    int          keep;
    atom_bytes.delete();
    put_rand(4);
    if ($urandom_range(0, 3) != 0) begin
      atom_bytes.push_back(tags.es_tag);
      case ($urandom_range(0, 9))
        0, 1:    len = 28'($urandom_range(0, 19));
        2:       len = 28'($urandom);
        default: len = 28'($urandom_range(20, 200));
      endcase
      put_len(len);
      put_rand(3);
    end else begin
      atom_bytes.push_back(other_than(tags.es_tag));
      put_rand(2);
    end
    atom_bytes.push_back($urandom_range(0, 9) == 0 ? other_than(tags.dec_config_tag)
                                                   : tags.dec_config_tag);
    len = ($urandom_range(0, 4) == 0) ? 28'($urandom_range(0, 14))
                                      : 28'($urandom_range(15, 300));
    put_len(len);
    put_rand(13);
    if (add_desc(tags.dec_specific_tag)) begin
      if (add_desc(tags.sl_config_tag)) begin
        if ($urandom_range(0, 4) == 0) put_rand($urandom_range(1, 4));
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      keep = $urandom_range(1, atom_bytes.size());
      while (atom_bytes.size() > keep) void'(atom_bytes.pop_back());
    end
  endfunction

  task automatic run_atoms(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 7) == 0) begin
        atom_bytes.delete();
        put_rand($urandom_range(1, 30));
      end else begin
        make_atom();
      end
      send_atom(0, atom_bytes.size());
      sent += atom_bytes.size();
    end
  endtask

  // full atom at reset tags: four-byte ES length of exactly 20, config length
  // of exactly 15, empty decoder specific payload, ends on the last SL byte
  task automatic test_reset_tags();
    atom_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h03, 8'h80, 8'h80, 8'h80, 8'h14,
                   8'hFF, 8'h00, 8'hFF, 8'h04, 8'h0F, 8'h00, 8'hFF, 8'hFF, 8'h00,
                   8'hFF, 8'h80, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'h05, 8'h00, 8'h06, 8'h02, 8'hAA, 8'h55};
    send_atom(0, atom_bytes.size());
  endtask

  task automatic test_early_end();
    atom_bytes = '{8'h5A};
    send_atom(0, atom_bytes.size());
  endtask

  task automatic test_tag_extremes();
    write_all_tags(8'h00, 8'hFF, 8'h00, 8'hFF);
    run_atoms(150);
    write_all_tags(8'hFF, 8'h00, 8'hFF, 8'h00);
    run_atoms(150);
  endtask

  // config tag changed after the flags, before the tag is compared
  task automatic test_mid_atom_write();
    esds_cfg_t  saved;
    logic [7:0] fresh;
    int         split;
    for (int r = 0; r < 3; r++) begin
      settle();
      fresh = 8'($urandom);
      saved = tags;
      tags.dec_config_tag = fresh;
      make_atom();
      tags = saved;
      split = (atom_bytes.size() < 4) ? atom_bytes.size() : 4;
      send_atom(0, split);
      settle();
      write_tag(REG_DC_TAG, fresh);
      send_atom(split, atom_bytes.size());
    end
  endtask

  task automatic test_random_tags();
    write_all_tags(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_atoms(150);
  endtask

  task automatic test_streaming();
    write_all_tags(ES_TAG_RST, DC_TAG_RST, DS_TAG_RST, SL_TAG_RST);
    send_gaps = 1'b0;
    pop_gaps = 1'b0;
    run_atoms(150);
  endtask

  initial begin
    tags = {ES_TAG_RST, DC_TAG_RST, DS_TAG_RST, SL_TAG_RST};
    clear_parse();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_tags();
    test_early_end();
    test_tag_extremes();
    test_mid_atom_write();
    test_random_tags();
    test_streaming();
    settle();
    repeat (12) @(posedge clk_i);
    if (errors == 0 && due_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
